/* rtl/pbpm_pkg.sv */
// Package for the packet buffer pool manager.
// Holds the pool constants, the channel payload types and the operation and status codes.
// No dependencies.
package pbpm_pkg;

  localparam int unsigned POOL_ENTRIES   = 32;
  localparam int unsigned IDX_W          = 5;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned OFS_W          = 11;
  localparam int unsigned TOT_W          = 16;
  localparam int unsigned HEADROOM_BYTES = 128;
  localparam int unsigned DATA_BYTES     = 1536;
  localparam int unsigned BUF_BYTES      = HEADROOM_BYTES + DATA_BYTES;

  localparam logic [3:0] FN_ALLOC  = 4'd0;
  localparam logic [3:0] FN_FREE   = 4'd1;
  localparam logic [3:0] FN_ADDREF = 4'd2;
  localparam logic [3:0] FN_PUSH   = 4'd3;
  localparam logic [3:0] FN_PULL   = 4'd4;
  localparam logic [3:0] FN_PUT    = 4'd5;
  localparam logic [3:0] FN_TRIM   = 4'd6;
  localparam logic [3:0] FN_CHAIN  = 4'd7;
  localparam logic [3:0] FN_QUERY  = 4'd8;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NOBUF = 3'd1,
    ST_ROOM  = 3'd2,
    ST_REF   = 3'd3,
    ST_LOOP  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_ALLOC,
    OP_FREE,
    OP_ADDREF,
    OP_PUSH,
    OP_PULL,
    OP_PUT,
    OP_TRIM,
    OP_CHAIN,
    OP_QUERY,
    OP_NOBUF
  } op_t;

  typedef struct packed {
    logic [3:0]       func;
    logic             buf_present;
    logic [IDX_W-1:0] buf_index;
    logic [IDX_W-1:0] other_index;
    logic [15:0]      length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] result_index;
    logic [OFS_W-1:0] data_offset;
    logic [OFS_W-1:0] buffer_length;
    logic [TOT_W-1:0] chain_total;
    logic [CNT_W-1:0] free_buffers;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] other;
    logic [15:0]      len;
  } cmd_t;

endpackage

/* rtl/pbpm_front.sv */
// Front end: accepts operations, decodes them into commands and queues them.
// Depends on pbpm_pkg.
module pbpm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pbpm_pkg::in_item_t in_data,
  output logic              q_valid,
  output pbpm_pkg::cmd_t    q_cmd,
  input  logic              q_pop
);

  pbpm_pkg::cmd_t q_mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  pbpm_pkg::cmd_t dec;
  logic           push;

  // classify the operation; a missing target is its own command
  always_comb begin
    dec.idx   = in_data.buf_index;
    dec.other = in_data.other_index;
    dec.len   = in_data.length;
    case (in_data.func)
      pbpm_pkg::FN_ALLOC:  dec.op = pbpm_pkg::OP_ALLOC;
      pbpm_pkg::FN_FREE:   dec.op = pbpm_pkg::OP_FREE;
      pbpm_pkg::FN_ADDREF: dec.op = pbpm_pkg::OP_ADDREF;
      pbpm_pkg::FN_PUSH:   dec.op = pbpm_pkg::OP_PUSH;
      pbpm_pkg::FN_PULL:   dec.op = pbpm_pkg::OP_PULL;
      pbpm_pkg::FN_PUT:    dec.op = pbpm_pkg::OP_PUT;
      pbpm_pkg::FN_TRIM:   dec.op = pbpm_pkg::OP_TRIM;
      pbpm_pkg::FN_CHAIN:  dec.op = pbpm_pkg::OP_CHAIN;
      default:             dec.op = pbpm_pkg::OP_QUERY;
    endcase
    if (in_data.func != pbpm_pkg::FN_ALLOC && !in_data.buf_present) begin
      dec.op = pbpm_pkg::OP_NOBUF;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* rtl/pbpm_back.sv */
// Back end: executes queued commands on the descriptor pool and registers the result.
// Depends on pbpm_pkg.
module pbpm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pbpm_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pbpm_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FREE, S_SEEK, S_SUM, S_DONE} state_t;

  localparam logic [pbpm_pkg::CNT_W-1:0] POOL_CNT = pbpm_pkg::CNT_W'(pbpm_pkg::POOL_ENTRIES);
  localparam logic [pbpm_pkg::OFS_W-1:0] HEADROOM = pbpm_pkg::OFS_W'(pbpm_pkg::HEADROOM_BYTES);
  localparam logic [16:0] BUF_END = 17'(pbpm_pkg::BUF_BYTES);

  state_t                            state_r;
  pbpm_pkg::cmd_t                    cmd_r;
  logic [pbpm_pkg::IDX_W-1:0]        free_link_r [pbpm_pkg::POOL_ENTRIES];
  logic                              chain_v_r   [pbpm_pkg::POOL_ENTRIES];
  logic [pbpm_pkg::IDX_W-1:0]        chain_to_r  [pbpm_pkg::POOL_ENTRIES];
  logic [7:0]                        ref_r       [pbpm_pkg::POOL_ENTRIES];
  logic [pbpm_pkg::OFS_W-1:0]        so_r        [pbpm_pkg::POOL_ENTRIES];
  logic [pbpm_pkg::OFS_W-1:0]        dl_r        [pbpm_pkg::POOL_ENTRIES];
  logic [pbpm_pkg::TOT_W-1:0]        ht_r        [pbpm_pkg::POOL_ENTRIES];
  logic [pbpm_pkg::IDX_W-1:0]        free_head_r;
  logic [pbpm_pkg::CNT_W-1:0]        free_total_r;
  logic [pbpm_pkg::IDX_W-1:0]        cur_r;
  logic [pbpm_pkg::CNT_W-1:0]        n_r;
  logic [pbpm_pkg::TOT_W-1:0]        sum_r;
  pbpm_pkg::status_t                 st_r;
  logic                              show_r;
  logic                              tail_sel_r;
  logic [pbpm_pkg::OFS_W-1:0]        tail_r;
  logic                              out_valid_r;
  pbpm_pkg::out_item_t               out_data_r;

  logic [pbpm_pkg::IDX_W-1:0]        b;
  logic [pbpm_pkg::OFS_W-1:0]        so_b, dl_b;
  logic [16:0]                       len17, so17, dl17, tail17;
  logic [pbpm_pkg::CNT_W-1:0]        n_inc;
  logic [16:0]                       sum_add;
  logic [pbpm_pkg::TOT_W-1:0]        sum_sat;
  logic                              out_busy;

  assign b       = cmd_r.idx;
  assign so_b    = so_r[b];
  assign dl_b    = dl_r[b];
  assign len17   = {1'b0, cmd_r.len};
  assign so17    = 17'(so_b);
  assign dl17    = 17'(dl_b);
  assign tail17  = so17 + dl17;
  assign n_inc   = n_r + 1'b1;
  assign sum_add = {1'b0, sum_r} + 17'(dl_r[cur_r]);
  assign sum_sat = sum_add[16] ? '1 : sum_add[pbpm_pkg::TOT_W-1:0];
  assign out_busy = out_valid_r && out_stall;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_head_r  <= pbpm_pkg::IDX_W'(pbpm_pkg::POOL_ENTRIES - 1);
      free_total_r <= POOL_CNT;
      for (int i = 0; i < pbpm_pkg::POOL_ENTRIES; i++) begin
        free_link_r[i] <= (i == 0) ? '0 : pbpm_pkg::IDX_W'(i - 1);
        chain_v_r[i]   <= 1'b0;
        chain_to_r[i]  <= '0;
        ref_r[i]       <= '0;
        so_r[i]        <= HEADROOM;
        dl_r[i]        <= '0;
        ht_r[i]        <= '0;
      end
    end else begin
      // S_DONE reloads the result register itself
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r      <= q_cmd;
            st_r       <= pbpm_pkg::ST_OK;
            show_r     <= 1'b1;
            tail_sel_r <= 1'b0;
            state_r    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= (cmd_r.op == pbpm_pkg::OP_FREE)  ? S_FREE :
                     (cmd_r.op == pbpm_pkg::OP_CHAIN) ? S_SEEK : S_DONE;
          case (cmd_r.op)
            pbpm_pkg::OP_NOBUF: begin
              st_r   <= pbpm_pkg::ST_NOBUF;
              show_r <= 1'b0;
            end
            pbpm_pkg::OP_ALLOC: begin
              if (free_total_r == '0) begin
                st_r   <= pbpm_pkg::ST_NOBUF;
                show_r <= 1'b0;
              end else begin
                // pop the free list head
                cmd_r.idx    <= free_head_r;
                free_total_r <= free_total_r - 1'b1;
                if (free_total_r != 6'd1) begin
                  free_head_r <= free_link_r[free_head_r];
                end
                so_r[free_head_r]      <= HEADROOM;
                dl_r[free_head_r]      <= '0;
                ht_r[free_head_r]      <= '0;
                chain_v_r[free_head_r] <= 1'b0;
                ref_r[free_head_r]     <= 8'd1;
              end
            end
            pbpm_pkg::OP_FREE: begin
              cur_r <= b;
              n_r   <= '0;
            end
            pbpm_pkg::OP_ADDREF: begin
              if (ref_r[b] == 8'd0 || ref_r[b] == 8'd255) begin
                st_r <= pbpm_pkg::ST_REF;
              end else begin
                ref_r[b] <= ref_r[b] + 8'd1;
              end
            end
            pbpm_pkg::OP_PUSH: begin
              if (len17 > so17) begin
                st_r <= pbpm_pkg::ST_ROOM;
              end else begin
                so_r[b] <= so_b - cmd_r.len[pbpm_pkg::OFS_W-1:0];
                dl_r[b] <= dl_b + cmd_r.len[pbpm_pkg::OFS_W-1:0];
              end
            end
            pbpm_pkg::OP_PULL: begin
              if (len17 > dl17) begin
                st_r <= pbpm_pkg::ST_ROOM;
              end else begin
                so_r[b] <= so_b + cmd_r.len[pbpm_pkg::OFS_W-1:0];
                dl_r[b] <= dl_b - cmd_r.len[pbpm_pkg::OFS_W-1:0];
              end
            end
            pbpm_pkg::OP_PUT: begin
              if (tail17 + len17 > BUF_END) begin
                st_r <= pbpm_pkg::ST_ROOM;
              end else begin
                dl_r[b]    <= dl_b + cmd_r.len[pbpm_pkg::OFS_W-1:0];
                tail_sel_r <= 1'b1;
                tail_r     <= tail17[pbpm_pkg::OFS_W-1:0];
              end
            end
            pbpm_pkg::OP_TRIM: begin
              if (len17 > dl17) begin
                st_r <= pbpm_pkg::ST_ROOM;
              end else begin
                dl_r[b] <= dl_b - cmd_r.len[pbpm_pkg::OFS_W-1:0];
              end
            end
            pbpm_pkg::OP_CHAIN: begin
              cur_r <= b;
              n_r   <= 6'd1;
            end
            default: begin
            end
          endcase
        end
        S_FREE: begin
          // one buffer of the chain per cycle
          if (ref_r[cur_r] == 8'd0) begin
            st_r    <= pbpm_pkg::ST_REF;
            state_r <= S_DONE;
          end else begin
            ref_r[cur_r] <= ref_r[cur_r] - 8'd1;
            if (ref_r[cur_r] == 8'd1 && free_total_r < POOL_CNT) begin
              free_link_r[cur_r] <= (free_total_r != '0) ? free_head_r : '0;
              free_head_r        <= cur_r;
              free_total_r       <= free_total_r + 1'b1;
            end
            n_r <= n_inc;
            if (!chain_v_r[cur_r]) begin
              state_r <= S_DONE;
            end else if (n_inc >= POOL_CNT) begin
              st_r    <= pbpm_pkg::ST_LOOP;
              state_r <= S_DONE;
            end else begin
              cur_r <= chain_to_r[cur_r];
            end
          end
        end
        S_SEEK: begin
          if (chain_v_r[cur_r]) begin
            if (n_r >= POOL_CNT) begin
              st_r    <= pbpm_pkg::ST_LOOP;
              state_r <= S_DONE;
            end else begin
              cur_r <= chain_to_r[cur_r];
              n_r   <= n_inc;
            end
          end else begin
            // link the appended chain, then recompute the head total
            chain_v_r[cur_r]  <= 1'b1;
            chain_to_r[cur_r] <= cmd_r.other;
            cur_r   <= b;
            n_r     <= '0;
            sum_r   <= '0;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          sum_r <= sum_sat;
          n_r   <= n_inc;
          if (!chain_v_r[cur_r]) begin
            ht_r[b] <= sum_sat;
            state_r <= S_DONE;
          end else if (n_inc >= POOL_CNT) begin
            ht_r[b] <= sum_sat;
            st_r    <= pbpm_pkg::ST_LOOP;
            state_r <= S_DONE;
          end else begin
            cur_r <= chain_to_r[cur_r];
          end
        end
        S_DONE: begin
          if (!out_busy) begin
            out_valid_r                <= 1'b1;
            out_data_r.status          <= st_r;
            out_data_r.result_index    <= show_r ? b : '0;
            out_data_r.data_offset     <= !show_r ? '0 : (tail_sel_r ? tail_r : so_b);
            out_data_r.buffer_length   <= show_r ? dl_b : '0;
            out_data_r.chain_total     <= show_r ? ht_r[b] : '0;
            out_data_r.free_buffers    <= free_total_r;
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/packet_buffer_pool_manager_top.sv */
// Top level of the packet buffer pool manager.
// Instantiates pbpm_front and pbpm_back; depends on pbpm_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one operation per
//   transaction: allocate, free chain, add reference, push, pull, put, trim,
//   chain or query. The result channel (out_valid, out_stall, out_data) returns
//   exactly one transaction per operation, in order.
//   The front end decodes each operation and places it in a two-entry queue;
//   in_stall rises only when that queue is full.
//   The back end executes one operation at a time from the queue:
//     - simple operations (alloc, add ref, push, pull, put, trim, query):
//       taken from the queue, then the descriptor read-modify-write, then
//       the result register is loaded;
//     - free chain: additionally visits each buffer of the chain (up to 32);
//     - chain: additionally walks the target chain to find its tail, then
//       sums each buffer of the chain for the new total (each walk up to 32).
//   The descriptor walk visits one buffer per cycle.
//   When the receiver stalls, the result holds in the output register, the
//   back end finishes its next operation and waits, and the queue fills.
//   Reset (rst_n low, synchronous) empties the queue and the result register,
//   puts all 32 descriptors on the free list, each empty with start offset 128.
module packet_buffer_pool_manager_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbpm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pbpm_pkg::out_item_t out_data
);

  logic           q_valid;
  logic           q_pop;
  pbpm_pkg::cmd_t q_cmd;

  // decode and queue
  pbpm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // execute against the descriptor pool
  pbpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/pbpm_checker.sv */
// Port-level checker for the packet buffer pool manager, bound to the top level.
// Depends on pbpm_pkg.
module pbpm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input pbpm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input pbpm_pkg::out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // hold a stalled operation
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled operation changed");

  // drop results after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_buffers <= 6'd32 && out_data.status <= 3'd4)
    else $error("result out of range");

  a_nobuf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == pbpm_pkg::ST_NOBUF |->
      out_data.result_index == '0 && out_data.chain_total == '0 &&
      out_data.buffer_length == '0)
    else $error("missing buffer reported fields");

endmodule

bind packet_buffer_pool_manager_top pbpm_checker u_pbpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
